// File: src/lcc_pkg.sv
package lcc_pkg;

  // Graph capacity
  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned MAX_EDGES  = 8192;
  localparam int unsigned MAX_DEGREE = 64;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned VAL_W   = 14;
  localparam int unsigned NODE_W  = 13;
  localparam int unsigned DEGO_W  = 14;
  localparam int unsigned ECNT_W  = 11;
  localparam int unsigned COEF_W  = 16;

  // Internal widths
  localparam int unsigned OFF_AW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EDGE_AW = $clog2(MAX_EDGES);
  localparam int unsigned BUF_AW  = $clog2(MAX_DEGREE);
  localparam int unsigned DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int unsigned DEN_W   = $clog2(MAX_DEGREE * (MAX_DEGREE - 1) + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_DEGREE * MAX_EDGES + 1);
  localparam int unsigned STEP_W  = $clog2(COEF_W);

  localparam logic [ECNT_W-1:0] EDGE_COUNT_MAX = ECNT_W'(2016);
  localparam logic [COEF_W-1:0] COEF_MAX       = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_OFFSET = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // write a table entry from the inputs
    logic latch_node;  // take the queried node
    logic off_next;    // address offset of node + 1
    logic latch_a;
    logic latch_b;
    logic set_k;       // take degree and first edge slot of the query
    logic out_early;   // report small degree or overflow
    logic gather_sel;  // address edge table at lo + i
    logic buf_wr;
    logic i_clr;
    logic i_inc;
    logic latch_v;     // take neighbor value and make it the node
    logic set_e;
    logic latch_t;
    logic buf_sel_j;
    logic j_clr;
    logic j_inc;
    logic e_inc;
    logic cnt_inc;
    logic den_calc;
    logic div_init;
    logic div_step;
    logic out_final;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic deg_small;
    logic deg_big;
    logic last_i;
    logic e_done;
    logic hit;
    logic last_j;
    logic div_sat;
    logic div_last;
  } sts_t;

endpackage

// File: src/lcc_ram.sv
module lcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lcc_ctrl.sv
module lcc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lcc_pkg::OP_W-1:0]    operation_i,
  input  lcc_pkg::sts_t               sts_i,
  output lcc_pkg::cmd_t               cmd_o,
  output logic                        busy_o
);
  import lcc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_Q_OFF0 = 5'd1;
  localparam logic [4:0] S_Q_OFF1 = 5'd2;
  localparam logic [4:0] S_Q_OFF2 = 5'd3;
  localparam logic [4:0] S_Q_EVAL = 5'd4;
  localparam logic [4:0] S_G_RD   = 5'd5;
  localparam logic [4:0] S_G_WR   = 5'd6;
  localparam logic [4:0] S_O_RD   = 5'd7;
  localparam logic [4:0] S_O_V    = 5'd8;
  localparam logic [4:0] S_N_OFF0 = 5'd9;
  localparam logic [4:0] S_N_OFF1 = 5'd10;
  localparam logic [4:0] S_N_OFF2 = 5'd11;
  localparam logic [4:0] S_N_EVAL = 5'd12;
  localparam logic [4:0] S_E_CHK  = 5'd13;
  localparam logic [4:0] S_E_RD   = 5'd14;
  localparam logic [4:0] S_E_T    = 5'd15;
  localparam logic [4:0] S_S_RD   = 5'd16;
  localparam logic [4:0] S_S_CMP  = 5'd17;
  localparam logic [4:0] S_D_MUL  = 5'd18;
  localparam logic [4:0] S_D_INIT = 5'd19;
  localparam logic [4:0] S_D_STEP = 5'd20;
  localparam logic [4:0] S_D_OUT  = 5'd21;

  logic [4:0] state_q, state_d;
  cmd_t       cmd;

  // Take loads in idle; sequence one query through range fetch, gather, tail search and divide
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load       = 1'b1;
          cmd.latch_node = 1'b1;
          if (operation_i == OP_QUERY) begin
            state_d = S_Q_OFF0;
          end
        end
      end
      S_Q_OFF0: state_d = S_Q_OFF1;
      S_Q_OFF1: begin
        cmd.latch_a  = 1'b1;
        cmd.off_next = 1'b1;
        state_d      = S_Q_OFF2;
      end
      S_Q_OFF2: begin
        cmd.latch_b = 1'b1;
        state_d     = S_Q_EVAL;
      end
      S_Q_EVAL: begin
        cmd.set_k = 1'b1;
        if (sts_i.deg_small || sts_i.deg_big) begin
          cmd.out_early = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd.i_clr = 1'b1;
          state_d   = S_G_RD;
        end
      end
      S_G_RD: begin
        cmd.gather_sel = 1'b1;
        state_d        = S_G_WR;
      end
      S_G_WR: begin
        cmd.buf_wr = 1'b1;
        if (sts_i.last_i) begin
          cmd.i_clr = 1'b1;
          state_d   = S_O_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_d   = S_G_RD;
        end
      end
      S_O_RD: state_d = S_O_V;
      S_O_V: begin
        cmd.latch_v = 1'b1;
        state_d     = S_N_OFF0;
      end
      S_N_OFF0: state_d = S_N_OFF1;
      S_N_OFF1: begin
        cmd.latch_a  = 1'b1;
        cmd.off_next = 1'b1;
        state_d      = S_N_OFF2;
      end
      S_N_OFF2: begin
        cmd.latch_b = 1'b1;
        state_d     = S_N_EVAL;
      end
      S_N_EVAL: begin
        cmd.set_e = 1'b1;
        state_d   = S_E_CHK;
      end
      S_E_CHK: begin
        if (!sts_i.e_done) begin
          state_d = S_E_RD;
        end else if (sts_i.last_i) begin
          state_d = S_D_MUL;
        end else begin
          cmd.i_inc = 1'b1;
          state_d   = S_O_RD;
        end
      end
      S_E_RD: state_d = S_E_T;
      S_E_T: begin
        cmd.latch_t = 1'b1;
        cmd.j_clr   = 1'b1;
        state_d     = S_S_RD;
      end
      S_S_RD: begin
        cmd.buf_sel_j = 1'b1;
        state_d       = S_S_CMP;
      end
      S_S_CMP: begin
        if (sts_i.hit) begin
          cmd.cnt_inc = 1'b1;
          cmd.e_inc   = 1'b1;
          state_d     = S_E_CHK;
        end else if (sts_i.last_j) begin
          cmd.e_inc = 1'b1;
          state_d   = S_E_CHK;
        end else begin
          cmd.j_inc = 1'b1;
          state_d   = S_S_RD;
        end
      end
      S_D_MUL: begin
        cmd.den_calc = 1'b1;
        state_d      = S_D_INIT;
      end
      S_D_INIT: begin
        cmd.div_init = 1'b1;
        state_d      = sts_i.div_sat ? S_D_OUT : S_D_STEP;
      end
      S_D_STEP: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_D_OUT;
        end
      end
      S_D_OUT: begin
        cmd.out_final = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

// File: src/lcc_dp.sv
module lcc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lcc_pkg::OP_W-1:0]     operation_i,
  input  logic [lcc_pkg::IDX_W-1:0]    index_i,
  input  logic [lcc_pkg::VAL_W-1:0]    value_i,
  input  lcc_pkg::cmd_t                cmd_i,
  output lcc_pkg::sts_t                sts_o,
  output logic                         done_o,
  output logic [lcc_pkg::DEGO_W-1:0]   node_degree_o,
  output logic [lcc_pkg::ECNT_W-1:0]   neighbor_edge_count_o,
  output logic [lcc_pkg::COEF_W-1:0]   coefficient_o,
  output logic                         overflow_o
);
  import lcc_pkg::*;

  logic [NODE_W-1:0]  node_q;
  logic [DEGO_W-1:0]  a_q, b_q, lo_q, k_q, e_q, eend_q;
  logic [DEG_W-1:0]   i_q, j_q;
  logic [NODE_W-1:0]  v_q, t_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W-1:0]   den_q, rem_q;
  logic [COEF_W-1:0]  quo_q;
  logic [STEP_W-1:0]  step_q;
  logic               done_q, ovf_q;
  logic [DEGO_W-1:0]  deg_out_q;
  logic [ECNT_W-1:0]  ecnt_out_q;
  logic [COEF_W-1:0]  coef_out_q;

  logic [OFF_AW-1:0]  off_raddr;
  logic [VAL_W-1:0]   off_rdata;
  logic [EDGE_AW-1:0] edge_raddr;
  logic [NODE_W-1:0]  edge_rdata;
  logic [BUF_AW-1:0]  buf_raddr;
  logic [NODE_W-1:0]  buf_rdata;
  logic               off_we, edge_we;

  logic [DEGO_W-1:0]  off_clamp;
  logic               node_ok, range_ok;
  logic [DEGO_W-1:0]  deg;
  logic [DEG_W-1:0]   k_small;
  logic [CNT_W:0]     cnt2;
  logic [DEN_W:0]     rem2;
  logic               rem_ge;
  logic [2*DEG_W-1:0] den_full;

  // Table writes straight from an accepted load transaction
  assign off_we  = cmd_i.load && (operation_i == OP_LOAD_OFFSET)
                   && ({1'b0, index_i} <= (IDX_W + 1)'(MAX_NODES));
  assign edge_we = cmd_i.load && (operation_i == OP_LOAD_EDGE)
                   && ({1'b0, index_i} < (IDX_W + 1)'(MAX_EDGES));

  assign off_raddr  = cmd_i.off_next ? OFF_AW'(node_q) + OFF_AW'(1) : OFF_AW'(node_q);
  assign edge_raddr = cmd_i.gather_sel ? EDGE_AW'(lo_q + DEGO_W'(i_q))
                                       : EDGE_AW'(e_q);
  assign buf_raddr  = cmd_i.buf_sel_j ? BUF_AW'(j_q) : BUF_AW'(i_q);

  lcc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES + 1)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (OFF_AW'(index_i)),
    .wdata_i (value_i),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  lcc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (EDGE_AW'(index_i)),
    .wdata_i (value_i[NODE_W-1:0]),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  lcc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_DEGREE)) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.buf_wr),
    .waddr_i (BUF_AW'(i_q)),
    .wdata_i (edge_rdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Clamp offsets past the edge table, derive the slot range
  assign off_clamp = (off_rdata > DEGO_W'(MAX_EDGES)) ? DEGO_W'(MAX_EDGES) : off_rdata;
  assign node_ok   = ({1'b0, node_q} < (NODE_W + 1)'(MAX_NODES));
  assign range_ok  = node_ok && (b_q >= a_q);
  assign deg       = range_ok ? (b_q - a_q) : '0;
  assign k_small   = k_q[DEG_W-1:0];

  assign cnt2     = {cnt_q, 1'b0};
  assign rem2     = {rem_q, 1'b0};
  assign rem_ge   = (rem2 >= {1'b0, den_q});
  assign den_full = (2*DEG_W)'(k_small) * (2*DEG_W)'(k_small - DEG_W'(1));

  // Status back to the controller
  always_comb begin
    sts_o.deg_small = (deg <= DEGO_W'(1));
    sts_o.deg_big   = (deg > DEGO_W'(MAX_DEGREE));
    sts_o.last_i    = (i_q == k_small - DEG_W'(1));
    sts_o.e_done    = (e_q == eend_q);
    sts_o.hit       = (buf_rdata == t_q)
                      && ((t_q > v_q) || ((t_q == v_q) && (j_q > i_q)));
    sts_o.last_j    = (j_q == k_small - DEG_W'(1));
    sts_o.div_sat   = (cnt2 >= (CNT_W + 1)'(den_q));
    sts_o.div_last  = (step_q == STEP_W'(COEF_W - 1));
  end

  // Working registers of the query
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_node) begin
      node_q <= index_i;
    end
    if (cmd_i.latch_v) begin
      node_q <= buf_rdata;
      v_q    <= buf_rdata;
    end
    if (cmd_i.latch_a) begin
      a_q <= off_clamp;
    end
    if (cmd_i.latch_b) begin
      b_q <= off_clamp;
    end
    if (cmd_i.set_k) begin
      k_q   <= deg;
      lo_q  <= a_q;
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.i_clr) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + DEG_W'(1);
    end
    if (cmd_i.set_e) begin
      e_q    <= a_q;
      eend_q <= range_ok ? b_q : a_q;
    end else if (cmd_i.e_inc) begin
      e_q <= e_q + DEGO_W'(1);
    end
    if (cmd_i.latch_t) begin
      t_q <= edge_rdata;
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + DEG_W'(1);
    end
    if (cmd_i.den_calc) begin
      den_q <= DEN_W'(den_full);
    end
    // Restoring divide of 2E * 2^16 by k(k-1), one quotient bit a cycle
    if (cmd_i.div_init) begin
      step_q <= '0;
      if (sts_o.div_sat) begin
        quo_q <= COEF_MAX;
      end else begin
        quo_q <= '0;
        rem_q <= DEN_W'(cnt2);
      end
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
      quo_q  <= {quo_q[COEF_W-2:0], rem_ge};
      rem_q  <= rem_ge ? DEN_W'(rem2 - {1'b0, den_q}) : DEN_W'(rem2);
    end
    // Result registers
    if (cmd_i.out_early) begin
      deg_out_q  <= deg;
      ecnt_out_q <= '0;
      coef_out_q <= '0;
      ovf_q      <= sts_o.deg_big;
    end else if (cmd_i.out_final) begin
      deg_out_q  <= k_q;
      ecnt_out_q <= (cnt_q > CNT_W'(EDGE_COUNT_MAX)) ? EDGE_COUNT_MAX
                                                      : ECNT_W'(cnt_q);
      coef_out_q <= quo_q;
      ovf_q      <= 1'b0;
    end
  end

  // Strobe each result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_early || cmd_i.out_final;
    end
  end

  assign done_o                = done_q;
  assign node_degree_o         = deg_out_q;
  assign neighbor_edge_count_o = ecnt_out_q;
  assign coefficient_o         = coef_out_q;
  assign overflow_o            = ovf_q;

endmodule

// File: src/local_clustering_coefficient.sv
// Local clustering coefficient of one node of an undirected CSR graph.
// Command channel: drive operation_i, index_i, value_i with start_i; the
// transaction is taken at a rising edge where start_i is high and busy_o low.
// Loads (offset entry, edge target) give no result and leave busy_o low.
// A query raises busy_o until its result is out.
// Result channel: done_o is high for exactly one cycle with node_degree_o,
// neighbor_edge_count_o, coefficient_o and overflow_o; it cannot be held off.
// Queries of degree 0, 1 or above 64 end after the range fetch. Otherwise the
// query gathers the k neighbors, then per neighbor fetches its range and per
// neighbor edge searches the buffer entries, then divides (cut short when
// saturated). The single read port of the neighborhood RAM, searched one
// entry at a time, bounds the run time.
// The next transaction may start in the cycle done_o is high.
// Reset clears the sequencer and the strobe only; the tables are undefined
// until loaded and need no clearing pass.
module local_clustering_coefficient (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [lcc_pkg::OP_W-1:0]     operation_i,
  input  logic [lcc_pkg::IDX_W-1:0]    index_i,
  input  logic [lcc_pkg::VAL_W-1:0]    value_i,
  output logic                         done_o,
  output logic [lcc_pkg::DEGO_W-1:0]   node_degree_o,
  output logic [lcc_pkg::ECNT_W-1:0]   neighbor_edge_count_o,
  output logic [lcc_pkg::COEF_W-1:0]   coefficient_o,
  output logic                         overflow_o
);
  import lcc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy;

  // Sequencer
  lcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  // Tables, counters and divider
  lcc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .operation_i           (operation_i),
    .index_i               (index_i),
    .value_i               (value_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .done_o                (done_o),
    .node_degree_o         (node_degree_o),
    .neighbor_edge_count_o (neighbor_edge_count_o),
    .coefficient_o         (coefficient_o),
    .overflow_o            (overflow_o)
  );

  assign busy_o = busy;

endmodule

// File: sim/local_clustering_coefficient_test.sv
module local_clustering_coefficient_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [DEGO_W-1:0] degree;
    logic [ECNT_W-1:0] edge_cnt;
    logic [COEF_W-1:0] coef;
    logic              ovf;
  } lcc_result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               typed;
    lcc_result_t      res;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OP_W-1:0]   operation_i;
  logic [IDX_W-1:0]  index_i;
  logic [VAL_W-1:0]  value_i;
  logic              done_o;
  logic [DEGO_W-1:0] node_degree_o;
  logic [ECNT_W-1:0] neighbor_edge_count_o;
  logic [COEF_W-1:0] coefficient_o;
  logic              overflow_o;

  local_clustering_coefficient DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .operation_i(operation_i), .index_i(index_i), .value_i(value_i),
    .done_o(done_o), .node_degree_o(node_degree_o),
    .neighbor_edge_count_o(neighbor_edge_count_o),
    .coefficient_o(coefficient_o), .overflow_o(overflow_o)
  );

  // Shadow copy of the graph tables
  logic [VAL_W-1:0]  graph_offsets [0:MAX_NODES];
  logic [NODE_W-1:0] graph_targets [0:MAX_EDGES-1];

  lcc_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamped_offset(int unsigned n);
    int unsigned v;
    v = graph_offsets[n];
    return (v > MAX_EDGES) ? MAX_EDGES : v;
  endfunction

  // Edge slots of node n; empty for out-of-range nodes and descending offsets
  function automatic void slot_range(int unsigned n, output int unsigned lo,
                                     output int unsigned hi);
    int unsigned a;
    int unsigned b;
    lo = 0;
    hi = 0;
    if (n < MAX_NODES) begin
      a = clamped_offset(n);
      b = clamped_offset(n + 1);
      if (b >= a) begin
        lo = a;
        hi = b;
      end
    end
  endfunction

  function automatic lcc_result_t clustering_of(int unsigned node);
    lcc_result_t r;
    int unsigned lo, hi, k, a, b, v, j;
    int unsigned nbrs [MAX_DEGREE];
    longint unsigned cnt, coef;
    bit found;
    slot_range(node, lo, hi);
    k = hi - lo;
    r = '0;
    r.degree = k[DEGO_W-1:0];
    if (k <= 1) return r;
    if (k > MAX_DEGREE) begin
      r.ovf = 1'b1;
      return r;
    end
    for (int unsigned i = 0; i < k; i++) nbrs[i] = graph_targets[lo + i];
    // Sort neighbors ascending
    for (int unsigned i = 1; i < k; i++) begin
      v = nbrs[i];
      j = i;
      while (j > 0 && nbrs[j-1] > v) begin
        nbrs[j] = nbrs[j-1];
        j--;
      end
      nbrs[j] = v;
    end
    // Count edges from each neighbor to later neighbors
    cnt = 0;
    for (int unsigned i = 0; i < k; i++) begin
      slot_range(nbrs[i], a, b);
      for (int unsigned e = a; e < b; e++) begin
        found = 1'b0;
        for (int unsigned t = i + 1; t < k; t++)
          if (nbrs[t] == graph_targets[e]) found = 1'b1;
        if (found) cnt++;
      end
    end
    coef = (cnt * 131072) / (longint'(k) * longint'(k - 1));
    r.coef = (coef > COEF_MAX) ? COEF_MAX : coef[COEF_W-1:0];
    r.edge_cnt = (cnt > EDGE_COUNT_MAX) ? EDGE_COUNT_MAX : cnt[ECNT_W-1:0];
    return r;
  endfunction

  // Drive one transaction and hold it until taken; start_i stays high after
  task automatic issue(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                       logic [VAL_W-1:0] val, bit typed, lcc_result_t res);
    start_i     <= 1'b1;
    operation_i <= op;
    index_i     <= idx;
    value_i     <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (op)
      OP_LOAD_OFFSET: if (idx <= MAX_NODES) graph_offsets[idx] = val;
      OP_LOAD_EDGE:   graph_targets[idx] = val[NODE_W-1:0];
      OP_QUERY:       pending_results.push_back(typed ? res : clustering_of(idx));
      default: ;
    endcase
  endtask

  task automatic idle(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] random_target();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 75) return VAL_W'($urandom_range(0, 31));
    if (p < 90) return VAL_W'($urandom_range(0, MAX_NODES - 1));
    return VAL_W'($urandom_range(0, 16383));
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, int unsigned idx, int unsigned val,
                                  bit typed, int unsigned deg, int unsigned ovf);
    stim_row_t row;
    row.op = op;
    row.idx = idx[IDX_W-1:0];
    row.val = val[VAL_W-1:0];
    row.typed = typed;
    row.res = '0;
    row.res.degree = deg[DEGO_W-1:0];
    row.res.ovf = ovf[0];
    directed_rows.push_back(row);
  endfunction

  // Compare every strobed result with the oldest expectation
  always @(posedge clk_i) begin
    lcc_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result deg=%0d", node_degree_o);
      end else begin
        want = pending_results.pop_front();
        if (node_degree_o !== want.degree || neighbor_edge_count_o !== want.edge_cnt ||
            coefficient_o !== want.coef || overflow_o !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected deg=%0d cnt=%0d coef=%0d ovf=%0d, got %0d %0d %0d %0d",
                     want.degree, want.edge_cnt, want.coef, want.ovf, node_degree_o,
                     neighbor_edge_count_o, coefficient_o, overflow_o);
        end
      end
    end
  end

  initial begin
    int unsigned deg, sum, p, idx, val, sent, burst;
    int signed delta;
    mismatches = 0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    operation_i <= OP_IGNORED;
    index_i     <= '0;
    value_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load a sparse graph: a dense cluster among the low nodes, a few fixed degrees
    sum = 0;
    for (int unsigned n = 0; n <= MAX_NODES; n++) begin
      issue(OP_LOAD_OFFSET, n, sum, 1'b0, '0);
      case (n)
        5:       deg = MAX_DEGREE;
        6:       deg = MAX_DEGREE + 6;
        7:       deg = 1;
        8:       deg = 0;
        default: deg = $urandom_range(0, 6);
      endcase
      sum += deg;
    end
    for (int unsigned s = 0; s < MAX_EDGES; s++)
      issue(OP_LOAD_EDGE, s, random_target(), 1'b0, '0);

    // Directed rows: small degrees, overflow, range edges, ignored loads
    add_row(OP_QUERY, 8, 0, 1, 0, 0);
    add_row(OP_QUERY, 7, 0, 1, 1, 0);
    add_row(OP_QUERY, 6, 0, 1, MAX_DEGREE + 6, 1);
    add_row(OP_QUERY, 2000, 0, 1, 0, 0);
    add_row(OP_QUERY, 8191, 0, 1, 0, 0);
    add_row(OP_QUERY, MAX_NODES, 0, 1, 0, 0);
    add_row(OP_QUERY, 5, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, 0, 0);
    add_row(OP_IGNORED, 8191, 16383, 0, 0, 0);
    add_row(OP_LOAD_OFFSET, 8191, 16383, 0, 0, 0);
    add_row(OP_LOAD_OFFSET, MAX_NODES + 1, 0, 0, 0, 0);
    add_row(OP_QUERY, 1023, 0, 0, 0, 0);
    add_row(OP_LOAD_EDGE, 8191, 16383, 0, 0, 0);
    add_row(OP_LOAD_OFFSET, MAX_NODES, 16383, 0, 0, 0);
    add_row(OP_QUERY, 1023, 0, 0, 0, 0);
    add_row(OP_LOAD_OFFSET, MAX_NODES, 0, 0, 0, 0);
    add_row(OP_QUERY, 1023, 0, 1, 0, 0);
    add_row(OP_LOAD_EDGE, 0, 0, 0, 0, 0);
    add_row(OP_QUERY, 1, 0, 0, 0, 0);
    add_row(OP_QUERY, 2, 0, 0, 0, 0);
    foreach (directed_rows[r]) begin
      issue(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
            directed_rows[r].typed, directed_rows[r].res);
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
    end
    drain();

    // Random traffic in bursts with gaps; mostly queries in the cluster
    sent = 0;
    while (sent < 300) begin
      burst = $urandom_range(1, 20);
      for (int unsigned b = 0; b < burst; b++) begin
        p = $urandom_range(0, 99);
        if (p < 50) begin
          idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 8191);
          issue(OP_QUERY, idx, $urandom_range(0, 16383), 1'b0, '0);
        end else if (p < 70) begin
          issue(OP_LOAD_EDGE, $urandom_range(0, MAX_EDGES - 1), random_target(), 1'b0, '0);
        end else if (p < 90) begin
          idx = $urandom_range(0, MAX_NODES);
          if ($urandom_range(0, 9) == 0) begin
            val = $urandom_range(0, 16383);
          end else begin
            delta = $urandom_range(0, 4);
            delta -= 2;
            val = (int'(graph_offsets[idx]) + delta < 0) ? 0 : int'(graph_offsets[idx]) + delta;
          end
          if ($urandom_range(0, 19) == 0) idx = $urandom_range(MAX_NODES + 1, 8191);
          issue(OP_LOAD_OFFSET, idx, val, 1'b0, '0);
        end else begin
          issue(OP_IGNORED, $urandom_range(0, 8191), $urandom_range(0, 16383), 1'b0, '0);
          sent--;
        end
        sent++;
      end
      if (sent > 150 && sent < 170) drain();
      else if ($urandom_range(0, 3) != 0) idle($urandom_range(0, 15));
    end

    // Wait out the last query, then report
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
